// ===== design/bep_pkg.sv =====
// ----------------------------------------------------------------------------
// bep_pkg
// shared types and constants for the beeper event pcm renderer
// ----------------------------------------------------------------------------
`default_nettype none

package bep_pkg;

  // configuration port geometry
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REG_IDX_W = 2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_VOLUME     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BEEP_MODE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = 2'd2;

  // beep modes
  localparam logic [1:0] MODE_LEVEL = 2'd0;
  localparam logic [1:0] MODE_RATE  = 2'd1;

  // input item kinds
  localparam logic KIND_EVENT  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // timing constants
  localparam logic [16:0] SAMPLE_UNITS = 17'h1_0000;
  localparam logic [30:0] IDLE_TIME    = 31'h4000_0000;
  localparam int unsigned PHASE_MSB    = 15;
  localparam int unsigned LEVEL_SHIFT  = 16 - 10;
  localparam int unsigned SQUARE_SHIFT = 10 - 2;

  typedef struct packed {
    logic [3:0]  volume;
    logic [1:0]  beep_mode;
    logic [15:0] phase_step;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/bep_ram.sv =====
// ----------------------------------------------------------------------------
// bep_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bep_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/bep_cfg.sv =====
// ----------------------------------------------------------------------------
// bep_cfg
// apb-style configuration registers: volume, beep mode, phase step
// ----------------------------------------------------------------------------
`default_nettype none

module bep_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bep_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [bep_pkg::DATA_W-1:0]  pwdata,
  output logic      [bep_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output bep_pkg::cfg_t                    cfg
);

  logic                             wr_en;
  logic [bep_pkg::REG_IDX_W-1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[bep_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        bep_pkg::REG_VOLUME:     cfg.volume     <= pwdata[3:0];
        bep_pkg::REG_BEEP_MODE:  cfg.beep_mode  <= pwdata[1:0];
        bep_pkg::REG_PHASE_STEP: cfg.phase_step <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bep_pkg::REG_VOLUME:     prdata = {28'd0, cfg.volume};
      bep_pkg::REG_BEEP_MODE:  prdata = {30'd0, cfg.beep_mode};
      bep_pkg::REG_PHASE_STEP: prdata = {16'd0, cfg.phase_step};
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/beeper_event_pcm_renderer_core.sv =====
// ----------------------------------------------------------------------------
// beeper_event_pcm_renderer_core
// turns queued beeper enable events into signed pcm samples
// ----------------------------------------------------------------------------
// usage
//   input channel (item_valid / item_stall) carries two kinds of item:
//     kind 0 queues an event (event_time, event_on); leaves the input free and is
//     dropped when the queue already holds QUEUE_DEPTH events
//     kind 1 requests one sample; exactly one sample item comes out on the
//     output channel (sample_valid / sample_stall)
//   sequencing: a sample item holds the input until the sequencer is back
//     in ST_IDLE; a silent or one-shot sample goes ST_START, ST_DONE; an
//     event-free rate-mode sample adds ST_DECIDE, and ST_SQUARE and ST_SCALE
//     while the level is high; an integrated sample goes ST_START, ST_DECIDE,
//     ST_LOOP, then ST_WAIT and ST_LOOP again for each fired event (each a queue
//     ram read), ST_SCALE, ST_DONE; the sample enters the output register as ST_DONE ends
//   the output register lets the next item in while a sample waits to be
//     taken; a later sample item waits in its last step until the register
//     frees, and item_stall stays high meanwhile
//   reset (synchronous, rst high): empties the queue, clears levels, phase
//     and config; the queue ram itself is not cleared and needs no sweep
//   configuration: apb registers volume (0x0), beep_mode (0x4), phase_step
//     (0x8); not enforced by the block: the user writes them only while the block is idle
// ----------------------------------------------------------------------------
`default_nettype none

module beeper_event_pcm_renderer_core #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input items
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire logic                        kind,
  input  wire logic [30:0]                 event_time,
  input  wire logic                        event_on,
  input  wire logic                        buffer_end,
  // output items
  output logic                             sample_valid,
  input  wire logic                        sample_stall,
  output logic signed [14:0]               sample,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bep_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [bep_pkg::DATA_W-1:0]  pwdata,
  output logic      [bep_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  // sequencer states
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,  // take items, write events
    ST_START  = 8'b0000_0010,  // silence checks, buffer start
    ST_DECIDE = 8'b0000_0100,  // square wave or level integration
    ST_LOOP   = 8'b0000_1000,  // walk events inside the window
    ST_WAIT   = 8'b0001_0000,  // ram read of the next event
    ST_SQUARE = 8'b0010_0000,  // four quarter-sample phase steps
    ST_SCALE  = 8'b0100_0000,  // volume multiply
    ST_DONE   = 8'b1000_0000   // hand over, buffer end commit
  } state_t;

  state_t          state;
  bep_pkg::cfg_t   cfg;

  // queue control
  logic [CNT_W-1:0] event_count;
  logic [IDX_W-1:0] read_index;
  logic [IDX_W-1:0] read_next;
  logic [SUM_W-1:0] wr_sum;
  logic [SUM_W-1:0] wr_wrap;
  logic             queue_full;
  logic             queue_we;
  logic [31:0]      rd_entry;
  logic [30:0]      rd_time;
  logic             rd_level;

  // render state
  logic [30:0]       time_left;
  logic              pending_level;
  logic              current_level;
  logic [15:0]       phase;
  logic              in_buffer;

  // per-sample work registers
  logic [16:0]       remain;
  logic [16:0]       acc;
  logic signed [3:0] sq_sum;
  logic [1:0]        sq_cnt;
  logic              square_path;
  logic              audible;
  logic              end_req;
  logic [14:0]       result;

  // datapath helpers
  logic              item_fire;
  logic              silent;
  logic              idle_one_shot;
  logic              mode_rate;
  logic              window_fires;
  logic [20:0]       lvl_prod;
  logic signed [8:0] sq_prod;
  logic signed [14:0] sq_scaled;

  bep_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // queue entry: enable level on top of the duration
  bep_ram #(
    .WIDTH (32),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (queue_we),
    .waddr (wr_wrap[IDX_W-1:0]),
    .wdata ({event_on, event_time}),
    .raddr (read_index),
    .rdata (rd_entry)
  );

  assign rd_time  = rd_entry[30:0];
  assign rd_level = rd_entry[31];

  // handshake: the sequencer takes one item at a time
  assign item_stall = (state != ST_IDLE);
  assign item_fire  = item_valid & ~item_stall;

  // write slot behind the unread events, circular over the depth
  assign wr_sum     = SUM_W'(read_index) + SUM_W'(event_count);
  assign wr_wrap    = (wr_sum >= SUM_W'(QUEUE_DEPTH)) ? wr_sum - SUM_W'(QUEUE_DEPTH) : wr_sum;
  assign queue_full = (event_count == CNT_W'(QUEUE_DEPTH));
  assign queue_we   = item_fire & (kind == bep_pkg::KIND_EVENT) & ~queue_full;
  assign read_next  = (read_index == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : read_index + 1'b1;

  // silence and mode decode
  assign mode_rate     = (cfg.beep_mode == bep_pkg::MODE_RATE);
  assign silent        = (cfg.volume == 4'd0) ||
                         ((cfg.beep_mode != bep_pkg::MODE_LEVEL) && !mode_rate);
  assign idle_one_shot = (cfg.beep_mode == bep_pkg::MODE_LEVEL) && !in_buffer &&
                         (event_count == '0);

  // the current event fires inside what is left of the window
  assign window_fires = ({14'd0, remain} >= time_left);

  // volume scaling
  assign lvl_prod  = 21'(acc) * 21'(cfg.volume);
  assign sq_prod   = 9'(sq_sum) * $signed({5'd0, cfg.volume});
  assign sq_scaled = 15'(sq_prod) <<< bep_pkg::SQUARE_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      event_count   <= '0;
      read_index    <= '0;
      time_left     <= '0;
      pending_level <= 1'b0;
      current_level <= 1'b0;
      phase         <= '0;
      in_buffer     <= 1'b0;
      sample_valid  <= 1'b0;
    end else begin
      // output register drains independently of the sequencer; in the last
      // step a new sample takes the place of the one leaving
      if (sample_valid && !sample_stall && (state != ST_DONE)) begin
        sample_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (item_fire) begin
            if (kind == bep_pkg::KIND_EVENT) begin
              if (!queue_full) begin
                event_count <= event_count + 1'b1;
              end
            end else begin
              end_req <= buffer_end;
              state   <= ST_START;
            end
          end
        end

        ST_START: begin
          // read data for read_index is valid here
          result <= '0;
          if (silent || idle_one_shot) begin
            audible <= 1'b0;
            state   <= ST_DONE;
          end else begin
            audible <= 1'b1;
            if (!in_buffer) begin
              in_buffer <= 1'b1;
              if (event_count != '0) begin
                time_left     <= rd_time;
                pending_level <= rd_level;
                read_index    <= read_next;
                event_count   <= event_count - 1'b1;
              end else begin
                time_left     <= bep_pkg::IDLE_TIME;
                pending_level <= current_level;
              end
            end
            state <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          if (mode_rate && (time_left >= 31'(bep_pkg::SAMPLE_UNITS))) begin
            // whole event-free sample: square wave while the level is high, else zero
            time_left <= time_left - 31'(bep_pkg::SAMPLE_UNITS);
            if (current_level) begin
              sq_sum <= '0;
              sq_cnt <= '0;
              state  <= ST_SQUARE;
            end else begin
              state  <= ST_DONE;
            end
          end else begin
            remain <= bep_pkg::SAMPLE_UNITS;
            acc    <= '0;
            state  <= ST_LOOP;
          end
        end

        ST_LOOP: begin
          if (window_fires) begin
            // event fires: integrate up to it, switch level, take the next
            remain        <= remain - 17'(time_left);
            acc           <= acc + (current_level ? 17'(time_left) : 17'd0);
            current_level <= pending_level;
            if (mode_rate) begin
              phase <= '0;
            end
            if (event_count != '0) begin
              time_left     <= rd_time;
              pending_level <= rd_level;
              read_index    <= read_next;
              event_count   <= event_count - 1'b1;
            end else begin
              time_left <= bep_pkg::IDLE_TIME;
            end
            state <= ST_WAIT;
          end else begin
            time_left   <= time_left - 31'(remain);
            acc         <= acc + (current_level ? remain : 17'd0);
            square_path <= 1'b0;
            state       <= ST_SCALE;
          end
        end

        ST_WAIT: begin
          state <= ST_LOOP;
        end

        ST_SQUARE: begin
          sq_sum <= sq_sum + (phase[bep_pkg::PHASE_MSB] ? 4'sd1 : -4'sd1);
          phase  <= phase + cfg.phase_step;
          sq_cnt <= sq_cnt + 1'b1;
          if (sq_cnt == 2'd3) begin
            square_path <= 1'b1;
            state       <= ST_SCALE;
          end
        end

        ST_SCALE: begin
          if (square_path) begin
            result <= sq_scaled;
          end else begin
            result <= 15'(lvl_prod >> bep_pkg::LEVEL_SHIFT);
          end
          state <= ST_DONE;
        end

        ST_DONE: begin
          if (!sample_valid || !sample_stall) begin
            sample       <= result;
            sample_valid <= 1'b1;
            // end of buffer: commit pending level, drop the queue
            if (audible && end_req) begin
              current_level <= pending_level;
              event_count   <= '0;
              read_index    <= '0;
              in_buffer     <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/bep_checker.sv =====
// ----------------------------------------------------------------------------
// bep_checker
// port-level checks for the beeper event pcm renderer
// ----------------------------------------------------------------------------
`default_nettype none

module bep_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        item_valid,
  input wire logic                        item_stall,
  input wire logic                        kind,
  input wire logic                        sample_valid,
  input wire logic                        sample_stall,
  input wire logic signed [14:0]          sample,
  input wire logic                        pready
);

  // samples stay inside the scaled range
  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    sample_valid |-> (sample >= -15'sd15360) && (sample <= 15'sd15360))
    else $error("sample out of range");

  // a waiting sample holds
  a_sample_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_stall |=> sample_valid && $stable(sample))
    else $error("stalled sample changed");

  // an event item leaves the input free for the next item
  a_event_single: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (kind == bep_pkg::KIND_EVENT) |=> !item_stall)
    else $error("event item blocked the input");

  // a sample item occupies the sequencer
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (kind == bep_pkg::KIND_SAMPLE) |=> item_stall)
    else $error("sample item did not stall input");

  // configuration port never waits
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind beeper_event_pcm_renderer_core bep_checker u_bep_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .kind         (kind),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .sample       (sample),
  .pready       (pready)
);

`default_nettype wire

// ===== dv/tb_beeper_event_pcm_renderer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_beeper_event_pcm_renderer_core
// self-checking bench: a built-in predictor of the event queue, level
// integration and square-wave phase tracks every accepted item, and each
// sample out of the block is matched against the oldest prediction
// ----------------------------------------------------------------------------

module tb_beeper_event_pcm_renderer_core;

  localparam int unsigned QDEPTH        = 128;
  localparam int unsigned LONG_HOLD     = 400;    // receiver hold-off for back-pressure
  localparam int unsigned SETTLE_CYCLES = 16;     // event items may still be in flight
  localparam int unsigned DRAIN_LIMIT   = 50000;  // cycles allowed for outstanding samples
  localparam int unsigned N_FIXED       = 7;      // phases with hand-picked settings
  localparam int unsigned N_PHASES      = 9;      // the rest are random settings

  // silent beep modes, not named in the package
  localparam logic [1:0] MODE_MUTE_2 = 2'd2;
  localparam logic [1:0] MODE_MUTE_3 = 2'd3;

  // directed rows: an event, a sample request, or a register write
  typedef enum logic [1:0] {ROW_EVENT, ROW_SAMPLE, ROW_WRITE} row_op_t;

  typedef struct packed {
    row_op_t     op;
    logic [30:0] arg;      // event duration or register value
    logic        flag;     // event level or buffer end
    logic [1:0]  reg_idx;
    logic        typed;    // expected sample given in the row
    logic [14:0] want;
  } dir_row_t;

  localparam int unsigned N_DIR = 33;
  localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
    // volume is still zero after reset
    '{ROW_SAMPLE, 31'd0,         1'b0, bep_pkg::REG_VOLUME,     1'b1, 15'd0},
    '{ROW_WRITE,  31'd15,        1'b0, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    // one-shot with nothing queued and no buffer open
    '{ROW_SAMPLE, 31'd0,         1'b0, bep_pkg::REG_VOLUME,     1'b1, 15'd0},
    // high after half a window, then a full window high
    '{ROW_EVENT,  31'h0000_8000, 1'b1, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    '{ROW_SAMPLE, 31'd0,         1'b0, bep_pkg::REG_VOLUME,     1'b1, 15'd7680},
    '{ROW_SAMPLE, 31'd0,         1'b0, bep_pkg::REG_VOLUME,     1'b1, 15'd15360},
    // zero duration and longest duration, queued while the buffer is open
    '{ROW_EVENT,  31'd0,         1'b0, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    '{ROW_EVENT,  31'h4000_0000, 1'b1, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    '{ROW_SAMPLE, 31'd0,         1'b0, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    '{ROW_SAMPLE, 31'd0,         1'b1, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    '{ROW_EVENT,  31'd0,         1'b0, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    '{ROW_EVENT,  31'h2AAA_AAAA, 1'b1, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    '{ROW_EVENT,  31'h1555_5555, 1'b0, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    '{ROW_SAMPLE, 31'd0,         1'b0, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    '{ROW_SAMPLE, 31'd0,         1'b1, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    // rate mode, buffer opened with an empty queue
    '{ROW_WRITE,  31'(bep_pkg::MODE_RATE), 1'b0, bep_pkg::REG_BEEP_MODE, 1'b0, 15'd0},
    '{ROW_WRITE,  31'h0000_4000, 1'b0, bep_pkg::REG_PHASE_STEP, 1'b0, 15'd0},
    '{ROW_SAMPLE, 31'd0,         1'b0, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    '{ROW_EVENT,  31'h0000_4000, 1'b0, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    '{ROW_SAMPLE, 31'd0,         1'b0, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    // silent modes swallow buffer end without touching state
    '{ROW_WRITE,  31'(MODE_MUTE_2), 1'b0, bep_pkg::REG_BEEP_MODE, 1'b0, 15'd0},
    '{ROW_SAMPLE, 31'd0,         1'b1, bep_pkg::REG_VOLUME,     1'b1, 15'd0},
    '{ROW_WRITE,  31'(MODE_MUTE_3), 1'b0, bep_pkg::REG_BEEP_MODE, 1'b0, 15'd0},
    '{ROW_SAMPLE, 31'd0,         1'b1, bep_pkg::REG_VOLUME,     1'b1, 15'd0},
    '{ROW_WRITE,  31'(bep_pkg::MODE_RATE), 1'b0, bep_pkg::REG_BEEP_MODE, 1'b0, 15'd0},
    '{ROW_WRITE,  31'd0,         1'b0, bep_pkg::REG_PHASE_STEP, 1'b0, 15'd0},
    '{ROW_SAMPLE, 31'd0,         1'b1, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    // event fires at once, then a square wave stuck low: most negative sample
    '{ROW_EVENT,  31'd0,         1'b1, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    '{ROW_SAMPLE, 31'd0,         1'b0, bep_pkg::REG_VOLUME,     1'b1, 15'd15360},
    '{ROW_SAMPLE, 31'd0,         1'b0, bep_pkg::REG_VOLUME,     1'b1, -15'sd15360},
    '{ROW_SAMPLE, 31'd0,         1'b1, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    '{ROW_WRITE,  31'd0,         1'b0, bep_pkg::REG_VOLUME,     1'b0, 15'd0},
    '{ROW_SAMPLE, 31'd0,         1'b1, bep_pkg::REG_VOLUME,     1'b1, 15'd0}
  };

  // hand-picked phase settings: full, quiet, fast and mid steps, silent ones
  logic [3:0]  phase_vol  [0:N_FIXED-1] = '{4'd15, 4'd1, 4'd15, 4'd7, 4'd0, 4'd9, 4'd4};
  logic [1:0]  phase_mode [0:N_FIXED-1] = '{bep_pkg::MODE_LEVEL, bep_pkg::MODE_RATE,
                                            bep_pkg::MODE_RATE, bep_pkg::MODE_RATE,
                                            bep_pkg::MODE_LEVEL, MODE_MUTE_2,
                                            bep_pkg::MODE_LEVEL};
  logic [15:0] phase_stp  [0:N_FIXED-1] = '{16'h0000, 16'h0800, 16'hFFFF, 16'h8000,
                                            16'h1234, 16'h4000, 16'hFFFF};

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        item_valid;
  logic                        item_stall;
  logic                        kind;
  logic [30:0]                 event_time;
  logic                        event_on;
  logic                        buffer_end;
  logic                        sample_valid;
  logic                        sample_stall;
  logic signed [14:0]          sample;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [bep_pkg::ADDR_W-1:0]  paddr;
  logic [bep_pkg::DATA_W-1:0]  pwdata;
  logic [bep_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  // predictor state: the event queue and the renderer's running values
  logic [30:0] ev_dur_q [0:QDEPTH-1];
  logic        ev_lvl_q [0:QDEPTH-1];
  int unsigned ev_count = 0;
  int unsigned rd_idx   = 0;
  logic [31:0] t_left   = '0;
  logic        pend_lvl = 1'b0;
  logic        cur_lvl  = 1'b0;
  logic        in_buf   = 1'b0;
  logic [15:0] ph       = '0;
  logic [3:0]  cfg_vol  = '0;
  logic [1:0]  cfg_mode = '0;
  logic [15:0] cfg_step = '0;

  logic [14:0] expected_samples [$];
  int unsigned fail_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned burst_left    = 1;
  bit          long_hold_req = 1'b0;

  always #10 clk = ~clk;

  beeper_event_pcm_renderer_core #(
    .QUEUE_DEPTH (QDEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .event_time   (event_time),
    .event_on     (event_on),
    .buffer_end   (buffer_end),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  // ---------------------------------------------------------------- predictor

  // append to the queue unless it is full (then the event is lost)
  function automatic void queue_event(logic [30:0] dur, logic lvl);
    int unsigned w;
    if (ev_count < QDEPTH) begin
      w = (rd_idx + ev_count) % QDEPTH;
      ev_dur_q[w] = dur;
      ev_lvl_q[w] = lvl;
      ev_count++;
    end
  endfunction

  function automatic bit pop_event();
    if (ev_count == 0) return 1'b0;
    t_left   = 32'(ev_dur_q[rd_idx]);
    pend_lvl = ev_lvl_q[rd_idx];
    rd_idx   = (rd_idx + 1) % QDEPTH;
    ev_count--;
    return 1'b1;
  endfunction

  // one quarter-sample of the square wave, advancing the phase
  function automatic int square_quarter();
    int v;
    v  = ph[bep_pkg::PHASE_MSB] ? 1 : -1;
    ph = ph + cfg_step;
    return v;
  endfunction

  function automatic logic [14:0] render_sample(logic bend);
    logic [31:0] remain;
    logic [31:0] acc;
    int          s;
    logic [14:0] res;
    res = '0;
    // silent settings leave every bit of state alone
    if (cfg_vol == 0 || cfg_mode > bep_pkg::MODE_RATE) return res;
    if (cfg_mode == bep_pkg::MODE_LEVEL && !in_buf && ev_count == 0) return res;
    // first audible request of a buffer loads the head event
    if (!in_buf) begin
      if (!pop_event()) begin
        t_left   = 32'(bep_pkg::IDLE_TIME);
        pend_lvl = cur_lvl;
      end
      in_buf = 1'b1;
    end
    if (cfg_mode == bep_pkg::MODE_RATE && t_left >= 32'(bep_pkg::SAMPLE_UNITS)) begin
      // event-free window in rate mode: four quarters of square wave while high
      t_left = t_left - 32'(bep_pkg::SAMPLE_UNITS);
      if (cur_lvl) begin
        s = square_quarter();
        s = s + square_quarter();
        s = s + square_quarter();
        s = s + square_quarter();
        s = s * int'(cfg_vol) * (1 << bep_pkg::SQUARE_SHIFT);
        res = s[14:0];
      end
    end else begin
      // box-integrate the high time over the window, firing events as they fall
      remain = 32'(bep_pkg::SAMPLE_UNITS);
      acc    = '0;
      while (remain >= t_left) begin
        remain = remain - t_left;
        if (cur_lvl) acc = acc + t_left;
        cur_lvl = pend_lvl;
        if (cfg_mode == bep_pkg::MODE_RATE) ph = '0;
        if (!pop_event()) t_left = 32'(bep_pkg::IDLE_TIME);
      end
      t_left = t_left - remain;
      if (cur_lvl) acc = acc + remain;
      acc = (acc * cfg_vol) >> bep_pkg::LEVEL_SHIFT;
      res = acc[14:0];
    end
    // buffer end commits the pending level and drops the rest of the queue
    if (bend) begin
      cur_lvl  = pend_lvl;
      ev_count = 0;
      rd_idx   = 0;
      in_buf   = 1'b0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- input side

  task automatic pause_sender(int unsigned n);
    if (n > 0) begin
      item_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // offer one item, hold it until taken, then predict; bursts end in a gap
  task automatic send_item(logic k, logic [30:0] dur, logic lvl, logic bend,
                           logic typed, logic [14:0] want);
    logic [14:0] predicted;
    item_valid <= 1'b1;
    kind       <= k;
    event_time <= dur;
    event_on   <= lvl;
    buffer_end <= bend;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (k == bep_pkg::KIND_EVENT) begin
      queue_event(dur, lvl);
    end else begin
      predicted = render_sample(bend);
      expected_samples.push_back(typed ? want : predicted);
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      pause_sender($urandom_range(1, 12));
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
    end
  endtask

  // hold the input quiet until every sample is back and the block is idle
  task automatic wait_idle();
    int unsigned guard;
    item_valid <= 1'b0;
    guard = 0;
    while (expected_samples.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (expected_samples.size() != 0)
      flag_error($sformatf("%0d samples never came out", expected_samples.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write, then read the register back
  task automatic write_reg(logic [bep_pkg::REG_IDX_W-1:0] idx,
                           logic [bep_pkg::DATA_W-1:0] val);
    logic [bep_pkg::DATA_W-1:0] mask;
    logic [bep_pkg::DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      bep_pkg::REG_VOLUME: begin
        mask    = 32'h0000_000F;
        cfg_vol = val[3:0];
      end
      bep_pkg::REG_BEEP_MODE: begin
        mask     = 32'h0000_0003;
        cfg_mode = val[1:0];
      end
      default: begin
        mask     = 32'h0000_FFFF;
        cfg_step = val[15:0];
      end
    endcase
    if ((rd & mask) !== (val & mask))
      flag_error($sformatf("register %0d reads 0x%0h, wrote 0x%0h", idx, rd, val));
  endtask

  function automatic logic [30:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return bep_pkg::IDLE_TIME;
      2:       return 31'($urandom) & 31'h3FFF_FFFF;
      3, 4:    return 31'($urandom_range(0, 16'hFFFF));
      default: return 31'($urandom_range(0, 32'h0003_0000));
    endcase
  endfunction

  // a well-formed buffer: events, then sample requests closed by buffer end
  task automatic play_buffer(int unsigned max_samples);
    int unsigned n_ev;
    int unsigned n_smp;
    n_ev  = $urandom_range(0, 12);
    n_smp = $urandom_range(1, max_samples);
    repeat (n_ev)
      send_item(bep_pkg::KIND_EVENT, pick_duration(), 1'($urandom), 1'($urandom),
                1'b0, '0);
    for (int i = 0; i < n_smp; i++) begin
      // late events join behind the unread ones
      if ($urandom_range(0, 5) == 0)
        send_item(bep_pkg::KIND_EVENT, pick_duration(), 1'($urandom), 1'b0, 1'b0, '0);
      send_item(bep_pkg::KIND_SAMPLE, 31'($urandom), 1'($urandom), (i == n_smp - 1),
                1'b0, '0);
    end
  endtask

  // anything goes: mixed kinds, stray buffer ends
  task automatic play_noise();
    repeat ($urandom_range(1, 10))
      send_item(1'($urandom), pick_duration(), 1'($urandom),
                ($urandom_range(0, 3) == 0), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------- output side

  // receiver stall: segments of random style, plus one long hold on request
  initial begin : sample_receiver
    int unsigned seg_left;
    int unsigned style;
    int unsigned hold_left;
    seg_left  = 0;
    style     = 0;
    hold_left = 0;
    sample_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        sample_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(8, 120);
          style    = $urandom_range(0, 3);
        end
        seg_left--;
        case (style)
          0:       sample_stall <= 1'b0;
          1:       sample_stall <= ($urandom_range(0, 3) == 0);
          2:       sample_stall <= ($urandom_range(0, 1) == 0);
          default: sample_stall <= ((seg_left % 5) < 2);
        endcase
      end
    end
  end

  // every accepted sample against the oldest prediction
  always @(posedge clk) begin : sample_check
    logic [14:0] want;
    if (!rst && sample_valid === 1'b1 && sample_stall === 1'b0) begin
      if (expected_samples.size() == 0) begin
        flag_error($sformatf("sample %0d with none expected", sample));
      end else begin
        want = expected_samples.pop_front();
        if (sample !== want)
          flag_error($sformatf("sample %0d, expected %0d", sample, $signed(want)));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : stimulus
    logic [3:0]  vol;
    logic [1:0]  mode;
    logic [15:0] stp;
    int unsigned stop_at;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    kind       <= bep_pkg::KIND_EVENT;
    event_time <= '0;
    event_on   <= 1'b0;
    buffer_end <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows; writes only once the block has gone quiet
    for (int r = 0; r < N_DIR; r++) begin
      case (DIR_ROWS[r].op)
        ROW_WRITE: begin
          wait_idle();
          write_reg(DIR_ROWS[r].reg_idx, 32'(DIR_ROWS[r].arg));
        end
        ROW_EVENT:
          send_item(bep_pkg::KIND_EVENT, DIR_ROWS[r].arg, DIR_ROWS[r].flag, 1'b0,
                    1'b0, '0);
        default:
          send_item(bep_pkg::KIND_SAMPLE, '0, 1'b0, DIR_ROWS[r].flag,
                    DIR_ROWS[r].typed, DIR_ROWS[r].want);
      endcase
    end

    // overfill the queue: the surplus events are lost
    wait_idle();
    write_reg(bep_pkg::REG_VOLUME, 32'd15);
    write_reg(bep_pkg::REG_BEEP_MODE, 32'(bep_pkg::MODE_LEVEL));
    repeat (QDEPTH + 12)
      send_item(bep_pkg::KIND_EVENT, 31'h300 + 31'($urandom_range(0, 255)), 1'($urandom),
                1'b0, 1'b0, '0);
    for (int i = 0; i < 4; i++)
      send_item(bep_pkg::KIND_SAMPLE, '0, 1'b0, (i == 3), 1'b0, '0);

    // random phases, each under its own register settings
    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      if (p < N_FIXED) begin
        vol  = phase_vol[p];
        mode = phase_mode[p];
        stp  = phase_stp[p];
      end else begin
        vol  = $urandom_range(1, 15);
        mode = ($urandom_range(0, 5) == 0) ? MODE_MUTE_3 : 2'($urandom_range(0, 1));
        stp  = $urandom;
      end
      write_reg(bep_pkg::REG_VOLUME, 32'(vol));
      write_reg(bep_pkg::REG_BEEP_MODE, 32'(mode));
      write_reg(bep_pkg::REG_PHASE_STEP, 32'(stp));
      stop_at = items_sent + ((vol == 0 || mode > bep_pkg::MODE_RATE) ? 60 : 200);
      if (p == 0) begin
        // receiver holds off while the sender keeps pushing, filling the block
        long_hold_req = 1'b1;
        burst_left    = 80;
        play_buffer(40);
      end
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 4) != 0) play_buffer(8);
        else play_noise();
      end
    end

    wait_idle();
    if (fail_count == 0)
      $display("tb_beeper_event_pcm_renderer_core: PASS");
    else
      $display("tb_beeper_event_pcm_renderer_core: FAIL");
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin : watchdog
    #60_000_000;
    $display("tb_beeper_event_pcm_renderer_core: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
design/bep_pkg.sv
design/bep_ram.sv
design/bep_cfg.sv
design/beeper_event_pcm_renderer_core.sv
design/bep_checker.sv
dv/tb_beeper_event_pcm_renderer_core.sv
